### design/die_pkg.sv
// Package: opcodes, result type and helper functions for the Dalvik execute block
`timescale 1ns / 1ps
`default_nettype none
package die_pkg;

  // Opcodes that are executed
  localparam logic [7:0] OP_MOVE               = 8'h01;
  localparam logic [7:0] OP_MOVE_FROM16        = 8'h02;
  localparam logic [7:0] OP_MOVE_16            = 8'h03;
  localparam logic [7:0] OP_MOVE_WIDE          = 8'h04;
  localparam logic [7:0] OP_MOVE_WIDE_FROM16   = 8'h05;
  localparam logic [7:0] OP_MOVE_WIDE_16       = 8'h06;
  localparam logic [7:0] OP_MOVE_OBJECT        = 8'h07;
  localparam logic [7:0] OP_MOVE_OBJECT_FROM16 = 8'h08;
  localparam logic [7:0] OP_MOVE_OBJECT_16     = 8'h09;
  localparam logic [7:0] OP_CONST_4            = 8'h12;
  localparam logic [7:0] OP_CONST_16           = 8'h13;
  localparam logic [7:0] OP_CONST              = 8'h14;
  localparam logic [7:0] OP_CONST_HIGH16       = 8'h15;
  localparam logic [7:0] OP_CONST_WIDE_16      = 8'h16;
  localparam logic [7:0] OP_CONST_WIDE_32      = 8'h17;
  localparam logic [7:0] OP_CONST_WIDE         = 8'h18;
  localparam logic [7:0] OP_CONST_WIDE_HIGH16  = 8'h19;
  localparam logic [7:0] OP_GOTO               = 8'h28;
  localparam logic [7:0] OP_GOTO_16            = 8'h29;
  localparam logic [7:0] OP_GOTO_32            = 8'h2A;
  localparam logic [7:0] OP_CMP_LONG           = 8'h2D;
  localparam logic [7:0] OP_CMPG_FLOAT         = 8'h2E;
  localparam logic [7:0] OP_CMPL_FLOAT         = 8'h2F;
  localparam logic [7:0] OP_CMPG_DOUBLE        = 8'h30;
  localparam logic [7:0] OP_CMPL_DOUBLE        = 8'h31;
  localparam logic [7:0] OP_IF_EQ              = 8'h32;
  localparam logic [7:0] OP_IF_LE              = 8'h37;
  localparam logic [7:0] OP_IF_EQZ             = 8'h38;
  localparam logic [7:0] OP_IF_LEZ             = 8'h3D;
  localparam logic [7:0] OP_NEG_INT            = 8'h7B;
  localparam logic [7:0] OP_NOT_INT            = 8'h7C;
  localparam logic [7:0] OP_ADD_INT            = 8'h90;
  localparam logic [7:0] OP_SUB_INT            = 8'h91;
  localparam logic [7:0] OP_ADD_INT_2ADDR      = 8'hB0;
  localparam logic [7:0] OP_SUB_INT_2ADDR      = 8'hB1;
  localparam logic [7:0] OP_ADD_INT_LIT16      = 8'hD0;
  localparam logic [7:0] OP_RSUB_INT           = 8'hD1;
  localparam logic [7:0] OP_ADD_INT_LIT8       = 8'hD8;
  localparam logic [7:0] OP_RSUB_INT_LIT8      = 8'hD9;

  // If-test condition selectors
  localparam logic [2:0] COND_EQ = 3'd0;
  localparam logic [2:0] COND_NE = 3'd1;
  localparam logic [2:0] COND_LT = 3'd2;
  localparam logic [2:0] COND_GE = 3'd3;
  localparam logic [2:0] COND_GT = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Compare results
  localparam logic [31:0] CMP_EQ = 32'h0000_0000;
  localparam logic [31:0] CMP_GT = 32'h0000_0001;
  localparam logic [31:0] CMP_LT = 32'hFFFF_FFFF;

  localparam logic [62:0] INF64 = 63'h7FF0_0000_0000_0000;
  localparam logic [30:0] INF32 = 31'h7F80_0000;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        branch_taken;
    logic [1:0]  write_count;
    logic [15:0] write_index;
    logic [63:0] write_value;
    logic [1:0]  status;
  } result_t;

  // Instruction length in bytes, zero for an unknown opcode
  function automatic logic [3:0] op_length(logic [7:0] op);
    logic [3:0] len;
    case (op) inside
      8'h00, 8'h01, 8'h04, 8'h07:                         len = 4'd2;
      8'h02, 8'h05, 8'h08:                                len = 4'd4;
      8'h03, 8'h06, 8'h09:                                len = 4'd6;
      [8'h0A:8'h12]:                                      len = 4'd2;
      8'h13, 8'h15, 8'h16, 8'h19, 8'h1A, 8'h1C:           len = 4'd4;
      8'h14, 8'h17, 8'h1B:                                len = 4'd6;
      8'h18:                                              len = 4'd10;
      8'h1D, 8'h1E, 8'h21, 8'h27, 8'h28:                  len = 4'd2;
      8'h1F, 8'h20, 8'h22, 8'h23, 8'h29:                  len = 4'd4;
      [8'h24:8'h26], 8'h2A, 8'h2B, 8'h2C:                 len = 4'd6;
      [8'h2D:8'h3D], [8'h44:8'h6D]:                       len = 4'd4;
      [8'h6E:8'h72], [8'h74:8'h78]:                       len = 4'd6;
      [8'h7B:8'h8F]:                                      len = 4'd2;
      [8'h90:8'hAF]:                                      len = 4'd4;
      [8'hB0:8'hCF]:                                      len = 4'd2;
      [8'hD0:8'hE2]:                                      len = 4'd4;
      default:                                            len = 4'd0;
    endcase
    return len;
  endfunction

  // First register read port: source index per opcode
  function automatic logic [15:0] src_a(logic [7:0] op, logic [63:0] ob);
    logic [15:0] s;
    case (op) inside
      OP_MOVE, OP_MOVE_OBJECT, OP_MOVE_WIDE,
      OP_ADD_INT_LIT16, OP_RSUB_INT:                      s = {12'd0, ob[7:4]};
      OP_MOVE_FROM16, OP_MOVE_OBJECT_FROM16,
      OP_MOVE_WIDE_FROM16:                                s = ob[23:8];
      OP_MOVE_16, OP_MOVE_OBJECT_16, OP_MOVE_WIDE_16:     s = ob[39:24];
      [OP_CMP_LONG:OP_CMPL_DOUBLE], OP_ADD_INT, OP_SUB_INT,
      OP_ADD_INT_LIT8, OP_RSUB_INT_LIT8:                  s = {8'd0, ob[15:8]};
      [OP_IF_EQ:OP_IF_LE], OP_NEG_INT, OP_NOT_INT,
      OP_ADD_INT_2ADDR, OP_SUB_INT_2ADDR:                 s = {12'd0, ob[3:0]};
      [OP_IF_EQZ:OP_IF_LEZ]:                              s = {8'd0, ob[7:0]};
      default:                                            s = 16'd0;
    endcase
    return s;
  endfunction

  // Second register read port: source index per opcode
  function automatic logic [15:0] src_b(logic [7:0] op, logic [63:0] ob);
    logic [15:0] s;
    case (op) inside
      [OP_CMP_LONG:OP_CMPL_DOUBLE], OP_ADD_INT, OP_SUB_INT: s = {8'd0, ob[23:16]};
      [OP_IF_EQ:OP_IF_LE], OP_NEG_INT, OP_NOT_INT,
      OP_ADD_INT_2ADDR, OP_SUB_INT_2ADDR:                 s = {12'd0, ob[7:4]};
      default:                                            s = 16'd0;
    endcase
    return s;
  endfunction

  // Float compare on raw bits; NaN gives the bias, -0 equals +0
  function automatic logic [31:0] fcmp32(logic [31:0] a, logic [31:0] b, logic gbias);
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] r;
    ka = a[31] ? ~a : {1'b1, a[30:0]};
    kb = b[31] ? ~b : {1'b1, b[30:0]};
    if (a[30:0] > INF32 || b[30:0] > INF32) r = gbias ? CMP_GT : CMP_LT;
    else if ((a[30:0] | b[30:0]) == 31'd0) r = CMP_EQ;
    else if (ka == kb) r = CMP_EQ;
    else r = (ka > kb) ? CMP_GT : CMP_LT;
    return r;
  endfunction

  function automatic logic [31:0] fcmp64(logic [63:0] a, logic [63:0] b, logic gbias);
    logic [63:0] ka;
    logic [63:0] kb;
    logic [31:0] r;
    ka = a[63] ? ~a : {1'b1, a[62:0]};
    kb = b[63] ? ~b : {1'b1, b[62:0]};
    if (a[62:0] > INF64 || b[62:0] > INF64) r = gbias ? CMP_GT : CMP_LT;
    else if ((a[62:0] | b[62:0]) == 63'd0) r = CMP_EQ;
    else if (ka == kb) r = CMP_EQ;
    else r = (ka > kb) ? CMP_GT : CMP_LT;
    return r;
  endfunction

endpackage
`default_nettype wire

### design/dalvik_instruction_execute_top.sv
// Top level: Dalvik instruction executor with banked register file and result register
// A result passes the input stage and the result register; m_tready low stalls both.
// One instruction per cycle unless stalled; the register file has an even and an odd
//   bank, each with two read ports, so a wide pair on each operand is read at once.
// Reset: pc cleared, then a clearing pass over every row of both banks zeroes the
//   register file; s_tready stays low until it ends.
`timescale 1ns / 1ps
`default_nettype none
module dalvik_instruction_execute_top #(
  parameter int REG_COUNT = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output      logic         s_tready,
  // opcode[7:0], operand_bytes[71:8], operand_last[79:72]
  input  wire logic [79:0]  s_tdata,
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  // next_pc[31:0], branch_taken[32], write_count[34:33], write_index[50:35],
  // write_value[114:51], status[116:115], zero fill[119:117]
  output      logic [119:0] m_tdata
);

  localparam int DEPTH = (REG_COUNT + 1) / 2;
  localparam int AW    = $clog2(DEPTH);

  logic             accept;
  logic             fire;
  logic             s1_valid;
  logic [7:0]       s1_op;
  logic [63:0]      s1_ob;
  logic [7:0]       s1_ol;
  logic [15:0]      s1_sa;
  logic [15:0]      s1_sb;
  logic [31:0]      pc;
  logic [1:0]       fwd_cnt;
  logic [15:0]      fwd_idx;
  logic [63:0]      fwd_val;
  logic             clr_busy;
  logic [AW-1:0]    clr_row;
  die_pkg::result_t res;
  die_pkg::result_t out;
  logic [15:0]      in_sa;
  logic [15:0]      in_sb;
  logic [16:0]      in_sa1;
  logic [16:0]      in_sb1;
  logic [16:0]      wr_idx1;
  logic             e_we;
  logic             o_we;
  logic [AW-1:0]    e_waddr;
  logic [AW-1:0]    o_waddr;
  logic [31:0]      e_wdata;
  logic [31:0]      o_wdata;
  logic [31:0]      e_rd0;
  logic [31:0]      e_rd1;
  logic [31:0]      o_rd0;
  logic [31:0]      o_rd1;
  logic [63:0]      op_a;
  logic [63:0]      op_b;

  // takes the write of the instruction that committed as the operands were read
  function automatic logic [31:0] byp(logic [16:0] idx, logic [31:0] mem,
                                      logic [1:0] cnt, logic [15:0] widx,
                                      logic [63:0] wval);
    logic [31:0] r;
    r = mem;
    if (cnt != 2'd0 && idx == {1'b0, widx}) r = wval[31:0];
    else if (cnt == 2'd2 && idx == ({1'b0, widx} + 17'd1)) r = wval[63:32];
    return r;
  endfunction

  // handshake
  assign fire     = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !clr_busy && (!s1_valid || fire);
  assign accept   = s_tvalid && s_tready;

  // read addresses from the incoming instruction
  assign in_sa  = die_pkg::src_a(s_tdata[7:0], s_tdata[71:8]);
  assign in_sb  = die_pkg::src_b(s_tdata[7:0], s_tdata[71:8]);
  assign in_sa1 = {1'b0, in_sa} + 17'd1;
  assign in_sb1 = {1'b0, in_sb} + 17'd1;

  // write port: clearing pass, else the committing instruction
  assign wr_idx1 = {1'b0, res.write_index} + 17'd1;
  always_comb begin
    if (clr_busy) begin
      e_we = 1'b1; o_we = 1'b1;
      e_waddr = clr_row; o_waddr = clr_row;
      e_wdata = 32'd0; o_wdata = 32'd0;
    end else begin
      e_we = fire && (res.write_count == 2'd2 ||
                      (res.write_count == 2'd1 && !res.write_index[0]));
      o_we = fire && (res.write_count == 2'd2 ||
                      (res.write_count == 2'd1 && res.write_index[0]));
      e_waddr = wr_idx1[AW:1];
      o_waddr = res.write_index[AW:1];
      e_wdata = res.write_index[0] ? res.write_value[63:32] : res.write_value[31:0];
      o_wdata = res.write_index[0] ? res.write_value[31:0] : res.write_value[63:32];
    end
  end

  die_bank #(.DEPTH(DEPTH), .AW(AW)) u_even (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .re(accept),
    .raddr0(in_sa1[AW:1]), .raddr1(in_sb1[AW:1]), .rdata0(e_rd0), .rdata1(e_rd1)
  );

  die_bank #(.DEPTH(DEPTH), .AW(AW)) u_odd (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata), .re(accept),
    .raddr0(in_sa[AW:1]), .raddr1(in_sb[AW:1]), .rdata0(o_rd0), .rdata1(o_rd1)
  );

  // operand words, low word at the source index
  always_comb begin
    op_a[31:0]  = byp({1'b0, s1_sa}, s1_sa[0] ? o_rd0 : e_rd0, fwd_cnt, fwd_idx, fwd_val);
    op_a[63:32] = byp({1'b0, s1_sa} + 17'd1, s1_sa[0] ? e_rd0 : o_rd0,
                      fwd_cnt, fwd_idx, fwd_val);
    op_b[31:0]  = byp({1'b0, s1_sb}, s1_sb[0] ? o_rd1 : e_rd1, fwd_cnt, fwd_idx, fwd_val);
    op_b[63:32] = byp({1'b0, s1_sb} + 17'd1, s1_sb[0] ? e_rd1 : o_rd1,
                      fwd_cnt, fwd_idx, fwd_val);
  end

  die_exec #(.REG_COUNT(REG_COUNT)) u_exec (
    .pc(pc), .opcode(s1_op), .ob(s1_ob), .ol(s1_ol), .a(op_a), .b(op_b), .res(res)
  );

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_row  <= '0;
    end else if (clr_busy) begin
      if (clr_row == AW'(DEPTH - 1)) clr_busy <= 1'b0;
      clr_row <= clr_row + AW'(1);
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op <= s_tdata[7:0];
      s1_ob <= s_tdata[71:8];
      s1_ol <= s_tdata[79:72];
      s1_sa <= in_sa;
      s1_sb <= in_sb;
    end
  end

  // commit: pc, last write for bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= 32'd0;
      fwd_cnt <= 2'd0;
    end else if (fire) begin
      pc      <= res.next_pc;
      fwd_cnt <= res.write_count;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      fwd_idx <= res.write_index;
      fwd_val <= res.write_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out <= res;
    end
  end

  assign m_tdata = {3'd0, out.status, out.write_value, out.write_index,
                    out.write_count, out.branch_taken, out.next_pc};

  // checks
  a_clr_no_accept: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s_tready) else $error("input taken during clearing pass");
  a_pc_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> pc == out.next_pc) else $error("pc does not match delivered next_pc");
  a_err_no_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out.status != die_pkg::ST_OK |-> out.write_count == 2'd0 &&
    !out.branch_taken) else $error("error result carries a write or branch");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out.write_count != 2'd3) else $error("bad write count");
  a_no_bank_write_on_error: assert property (@(posedge clk) disable iff (rst)
    fire && res.status != die_pkg::ST_OK |-> !e_we && !o_we)
    else $error("register file written by failed instruction");

endmodule
`default_nettype wire

### design/die_bank.sv
// One bank of the register file: one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none
module die_bank #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr0,
  input  wire logic [AW-1:0] raddr1,
  output      logic [31:0]   rdata0,
  output      logic [31:0]   rdata1
);

  logic [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule
`default_nettype wire

### design/die_exec.sv
// Execute logic: decodes one instruction and forms its result and write
`timescale 1ns / 1ps
`default_nettype none
module die_exec #(
  parameter int REG_COUNT = 256
) (
  input  wire logic [31:0]     pc,
  input  wire logic [7:0]      opcode,
  input  wire logic [63:0]     ob,
  input  wire logic [7:0]      ol,
  input  wire logic [63:0]     a,
  input  wire logic [63:0]     b,
  output      die_pkg::result_t res
);

  localparam logic [16:0] RC = 17'(REG_COUNT);

  function automatic logic fits(logic [15:0] idx, logic [1:0] n);
    return ({1'b0, idx} + {15'd0, n}) <= RC;
  endfunction

  function automatic logic cond(logic [2:0] sel, logic [31:0] x, logic [31:0] y);
    logic r;
    case (sel)
      die_pkg::COND_EQ: r = (x == y);
      die_pkg::COND_NE: r = (x != y);
      die_pkg::COND_LT: r = ($signed(x) <  $signed(y));
      die_pkg::COND_GE: r = ($signed(x) >= $signed(y));
      die_pkg::COND_GT: r = ($signed(x) >  $signed(y));
      default:          r = ($signed(x) <= $signed(y));
    endcase
    return r;
  endfunction

  logic [3:0]  len;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [15:0] na;
  logic [15:0] nb;
  logic [15:0] h1;
  logic [15:0] h3;
  logic [31:0] w1;
  logic [31:0] h1s;
  logic [31:0] off;
  logic [31:0] lit;
  logic        bad;

  assign len = die_pkg::op_length(opcode);
  assign b0  = ob[7:0];
  assign b1  = ob[15:8];
  assign b2  = ob[23:16];
  assign na  = {12'd0, ob[3:0]};
  assign nb  = {12'd0, ob[7:4]};
  assign h1  = ob[23:8];
  assign h3  = ob[39:24];
  assign w1  = ob[39:8];
  assign h1s = {{16{h1[15]}}, h1};

  // decode and execute
  always_comb begin
    res = '0;
    res.next_pc = pc + {28'd0, len};
    bad = 1'b0;
    off = 32'd0;
    lit = 32'd0;
    case (opcode)
      die_pkg::OP_MOVE, die_pkg::OP_MOVE_OBJECT: begin
        bad = !fits(na, 2'd1) || !fits(nb, 2'd1);
        res.write_count = 2'd1; res.write_index = na; res.write_value = {32'd0, a[31:0]};
      end
      die_pkg::OP_MOVE_FROM16, die_pkg::OP_MOVE_OBJECT_FROM16: begin
        bad = !fits({8'd0, b0}, 2'd1) || !fits(h1, 2'd1);
        res.write_count = 2'd1; res.write_index = {8'd0, b0};
        res.write_value = {32'd0, a[31:0]};
      end
      die_pkg::OP_MOVE_16, die_pkg::OP_MOVE_OBJECT_16: begin
        bad = !fits(h1, 2'd1) || !fits(h3, 2'd1);
        res.write_count = 2'd1; res.write_index = h1; res.write_value = {32'd0, a[31:0]};
      end
      die_pkg::OP_MOVE_WIDE: begin
        bad = !fits(na, 2'd2) || !fits(nb, 2'd2);
        res.write_count = 2'd2; res.write_index = na; res.write_value = a;
      end
      die_pkg::OP_MOVE_WIDE_FROM16: begin
        bad = !fits({8'd0, b0}, 2'd2) || !fits(h1, 2'd2);
        res.write_count = 2'd2; res.write_index = {8'd0, b0}; res.write_value = a;
      end
      die_pkg::OP_MOVE_WIDE_16: begin
        bad = !fits(h1, 2'd2) || !fits(h3, 2'd2);
        res.write_count = 2'd2; res.write_index = h1; res.write_value = a;
      end
      die_pkg::OP_CONST_4: begin
        bad = !fits(na, 2'd1);
        res.write_count = 2'd1; res.write_index = na;
        res.write_value = {32'd0, {28{ob[7]}}, ob[7:4]};
      end
      die_pkg::OP_CONST_16, die_pkg::OP_CONST, die_pkg::OP_CONST_HIGH16: begin
        bad = !fits({8'd0, b0}, 2'd1);
        res.write_count = 2'd1; res.write_index = {8'd0, b0};
        if (opcode == die_pkg::OP_CONST_16) res.write_value = {32'd0, h1s};
        else if (opcode == die_pkg::OP_CONST) res.write_value = {32'd0, w1};
        else res.write_value = {32'd0, h1, 16'd0};
      end
      die_pkg::OP_CONST_WIDE_16, die_pkg::OP_CONST_WIDE_32, die_pkg::OP_CONST_WIDE,
      die_pkg::OP_CONST_WIDE_HIGH16: begin
        bad = !fits({8'd0, b0}, 2'd2);
        res.write_count = 2'd2; res.write_index = {8'd0, b0};
        if (opcode == die_pkg::OP_CONST_WIDE_16) res.write_value = {{32{h1s[31]}}, h1s};
        else if (opcode == die_pkg::OP_CONST_WIDE_32) res.write_value = {{32{w1[31]}}, w1};
        else if (opcode == die_pkg::OP_CONST_WIDE) res.write_value = {ol, ob[63:8]};
        else res.write_value = {h1, 48'd0};
      end
      die_pkg::OP_GOTO, die_pkg::OP_GOTO_16, die_pkg::OP_GOTO_32: begin
        if (opcode == die_pkg::OP_GOTO) off = {{24{b0[7]}}, b0};
        else if (opcode == die_pkg::OP_GOTO_16) off = h1s;
        else off = w1;
        res.next_pc = pc + {off[30:0], 1'b0};
        res.branch_taken = 1'b1;
      end
      die_pkg::OP_CMP_LONG, die_pkg::OP_CMPG_DOUBLE, die_pkg::OP_CMPL_DOUBLE: begin
        bad = !fits({8'd0, b0}, 2'd1) || !fits({8'd0, b1}, 2'd2) ||
              !fits({8'd0, b2}, 2'd2);
        res.write_count = 2'd1; res.write_index = {8'd0, b0};
        if (opcode == die_pkg::OP_CMP_LONG) begin
          if (a == b) res.write_value = {32'd0, die_pkg::CMP_EQ};
          else if ($signed(a) > $signed(b)) res.write_value = {32'd0, die_pkg::CMP_GT};
          else res.write_value = {32'd0, die_pkg::CMP_LT};
        end else begin
          res.write_value = {32'd0,
            die_pkg::fcmp64(a, b, opcode == die_pkg::OP_CMPG_DOUBLE)};
        end
      end
      die_pkg::OP_CMPG_FLOAT, die_pkg::OP_CMPL_FLOAT: begin
        bad = !fits({8'd0, b0}, 2'd1) || !fits({8'd0, b1}, 2'd1) ||
              !fits({8'd0, b2}, 2'd1);
        res.write_count = 2'd1; res.write_index = {8'd0, b0};
        res.write_value = {32'd0,
          die_pkg::fcmp32(a[31:0], b[31:0], opcode == die_pkg::OP_CMPG_FLOAT)};
      end
      die_pkg::OP_NEG_INT, die_pkg::OP_NOT_INT, die_pkg::OP_ADD_INT_2ADDR,
      die_pkg::OP_SUB_INT_2ADDR: begin
        bad = !fits(na, 2'd1) || !fits(nb, 2'd1);
        res.write_count = 2'd1; res.write_index = na;
        if (opcode == die_pkg::OP_NEG_INT) res.write_value = {32'd0, 32'd0 - b[31:0]};
        else if (opcode == die_pkg::OP_NOT_INT) res.write_value = {32'd0, ~b[31:0]};
        else if (opcode == die_pkg::OP_ADD_INT_2ADDR)
          res.write_value = {32'd0, a[31:0] + b[31:0]};
        else res.write_value = {32'd0, a[31:0] - b[31:0]};
      end
      die_pkg::OP_ADD_INT, die_pkg::OP_SUB_INT: begin
        bad = !fits({8'd0, b0}, 2'd1) || !fits({8'd0, b1}, 2'd1) ||
              !fits({8'd0, b2}, 2'd1);
        res.write_count = 2'd1; res.write_index = {8'd0, b0};
        res.write_value = (opcode == die_pkg::OP_ADD_INT) ? {32'd0, a[31:0] + b[31:0]}
                                                          : {32'd0, a[31:0] - b[31:0]};
      end
      die_pkg::OP_ADD_INT_LIT16, die_pkg::OP_RSUB_INT: begin
        lit = h1s;
        bad = !fits(na, 2'd1) || !fits(nb, 2'd1);
        res.write_count = 2'd1; res.write_index = na;
        res.write_value = (opcode == die_pkg::OP_ADD_INT_LIT16) ? {32'd0, a[31:0] + lit}
                                                                : {32'd0, lit - a[31:0]};
      end
      die_pkg::OP_ADD_INT_LIT8, die_pkg::OP_RSUB_INT_LIT8: begin
        lit = {{24{b2[7]}}, b2};
        bad = !fits({8'd0, b0}, 2'd1) || !fits({8'd0, b1}, 2'd1);
        res.write_count = 2'd1; res.write_index = {8'd0, b0};
        res.write_value = (opcode == die_pkg::OP_ADD_INT_LIT8) ? {32'd0, a[31:0] + lit}
                                                               : {32'd0, lit - a[31:0]};
      end
      default: begin
        // if-tests, and placeholders that only advance the pc
        if (opcode >= die_pkg::OP_IF_EQ && opcode <= die_pkg::OP_IF_LE) begin
          bad = !fits(na, 2'd1) || !fits(nb, 2'd1);
          if (cond(3'(opcode - die_pkg::OP_IF_EQ), a[31:0], b[31:0])) begin
            res.next_pc = pc + {h1s[30:0], 1'b0};
            res.branch_taken = 1'b1;
          end
        end else if (opcode >= die_pkg::OP_IF_EQZ && opcode <= die_pkg::OP_IF_LEZ) begin
          bad = !fits({8'd0, b0}, 2'd1);
          if (cond(3'(opcode - die_pkg::OP_IF_EQZ), a[31:0], 32'd0)) begin
            res.next_pc = pc + {h1s[30:0], 1'b0};
            res.branch_taken = 1'b1;
          end
        end
      end
    endcase
    // error cases change nothing
    if (len == 4'd0) begin
      res = '0;
      res.next_pc = pc;
      res.status = die_pkg::ST_UNKNOWN;
    end else if (bad) begin
      res = '0;
      res.next_pc = pc;
      res.status = die_pkg::ST_RANGE;
    end
  end

endmodule
`default_nettype wire
